/* src/interval_pair_ring_queue_assert.svh */
// ----------------------------------------------------------------------------
// Interval pair ring queue assertion macros
// Thin wrappers around concurrent assertions, clocked on the rising edge and
// disabled during active-low reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_PAIR_RING_QUEUE_ASSERT_SVH
`define INTERVAL_PAIR_RING_QUEUE_ASSERT_SVH

// same-cycle implication
`define IPQ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ipq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipq_pkg
// Codes, widths and defaults of the interval pair ring queue.
// ----------------------------------------------------------------------------
package ipq_pkg;

  localparam int PAIR_SLOTS_DEF = 64;
  localparam int WORD_W         = 64;
  localparam int ACT_W          = 2;
  localparam int FILL_W         = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_DEQ     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENQ     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DOUBLE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_ENQ_ALT = 2'd3;  // treated as single enqueue

  // fill status codes
  localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
  localparam logic [FILL_W-1:0] FILL_MID   = 2'd1;
  localparam logic [FILL_W-1:0] FILL_FULL  = 2'd2;

  // stream packing
  localparam int IN_TDATA_W  = 4 * WORD_W;
  localparam int OUT_PAY_W   = 2 * WORD_W + FILL_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  // result waiting for the output register
  typedef struct packed {
    logic              ok;
    logic              deq;   // accepted dequeue: data comes from the store
    logic [FILL_W-1:0] fill;
  } res_t;

endpackage

`default_nettype wire

/* src/interval_pair_ring_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_pair_ring_queue
// Circular queue of 64-bit interval endpoint pairs held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transaction carries an action in in_tuser
//   (dequeue, enqueue one pair, enqueue two pairs) and up to two pairs in
//   in_tdata. Result channel (out_*): exactly one transaction per input,
//   in order, with the accepted flag in out_tuser and the popped pair plus
//   the fill status afterwards in out_tdata.
//   Result path: the result passes through the pending slot (pend_r) into the
//   output register; a double enqueue first does its second store write.
//   Throughput: one item per cycle while the output is not stalled, but an
//   accepted double enqueue holds off the next input during its second
//   write; set by the single store port (one read or one write per cycle).
//   A new input is taken in the cycle the previous result moves into the
//   output register, so a result waiting at the output does not block it.
//   Reset (rst_n low, synchronous): pointers cleared, status empty, output
//   invalid. Store contents are not cleared; no clearing pass is needed.
//   Receiver stall: the result holds in out_tdata/out_tuser; one further
//   item completes into a pending slot, then in_tready drops until the
//   output register drains.
// ----------------------------------------------------------------------------
`include "interval_pair_ring_queue_assert.svh"

module interval_pair_ring_queue
  import ipq_pkg::*;
#(
  parameter int PAIR_SLOTS = PAIR_SLOTS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // input channel
  input  wire                      in_tvalid,
  output logic                     in_tready,
  // in_tdata: first_low[63:0], first_high[127:64], second_low[191:128],
  //           second_high[255:192]
  input  wire  [IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: action[1:0]
  input  wire  [ACT_W-1:0]         in_tuser,
  // result channel
  output logic                     out_tvalid,
  input  wire                      out_tready,
  // out_tdata: out_low[63:0], out_high[127:64], fill_state[129:128], zero pad
  output logic [OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: accepted[0]
  output logic                     out_tuser
);

  localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PAIR_SLOTS - 1);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WR2  = 2'd1;  // second write of a double enqueue
  localparam logic [1:0] S_OUT  = 2'd2;  // result waits for the output register

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  // pair stores
  logic [WORD_W-1:0] left_mem  [PAIR_SLOTS];
  logic [WORD_W-1:0] right_mem [PAIR_SLOTS];

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] rd_r, rd_nxt;
  logic [SLOT_W-1:0] wr_r, wr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic              out_user_r;

  // second pair held for the second write of a double enqueue
  logic [SLOT_W-1:0] sec_addr_r;
  logic [WORD_W-1:0] sec_lo_r, sec_hi_r;
  logic [WORD_W-1:0] rd_lo_r, rd_hi_r;

  logic [WORD_W-1:0] first_lo, first_hi, second_lo, second_hi;
  logic [ACT_W-1:0]  act;
  logic              in_acc, out_free, out_load;
  logic [SLOT_W-1:0] rd_inc, wr_inc, wr_inc2;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wlo, mem_whi;
  logic              go_wr2;

  assign first_lo  = in_tdata[WORD_W-1:0];
  assign first_hi  = in_tdata[2*WORD_W-1:WORD_W];
  assign second_lo = in_tdata[3*WORD_W-1:2*WORD_W];
  assign second_hi = in_tdata[4*WORD_W-1:3*WORD_W];
  assign act       = in_tuser;

  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_OUT) && out_free;
  assign in_tready = (state_r == S_IDLE) || out_load;
  assign in_acc    = in_tvalid && in_tready;

  assign rd_inc  = slot_inc(rd_r);
  assign wr_inc  = slot_inc(wr_r);
  assign wr_inc2 = slot_inc(wr_inc);

  // decision is made in the accept cycle from the current pointers
  always_comb begin
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    fill_nxt  = fill_r;
    pend_nxt  = pend_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wr_r;
    mem_wlo   = first_lo;
    mem_whi   = first_hi;
    go_wr2    = 1'b0;
    if (in_acc) begin
      pend_nxt = '{ok: 1'b0, deq: 1'b0, fill: fill_r};
      unique case (act) inside
        ACT_DEQ: begin
          if (fill_r != FILL_EMPTY) begin
            mem_re   = 1'b1;
            rd_nxt   = rd_inc;
            fill_nxt = (rd_inc == wr_r) ? FILL_EMPTY : FILL_MID;
            pend_nxt = '{ok: 1'b1, deq: 1'b1, fill: fill_nxt};
          end
        end
        ACT_DOUBLE: begin
          // two free slots: empty, or partly filled with a gap above one
          if (fill_r == FILL_EMPTY || (fill_r == FILL_MID && wr_inc != rd_r)) begin
            mem_we   = 1'b1;
            go_wr2   = 1'b1;
            wr_nxt   = wr_inc2;
            fill_nxt = (wr_inc2 == rd_r) ? FILL_FULL : FILL_MID;
            pend_nxt = '{ok: 1'b1, deq: 1'b0, fill: fill_nxt};
          end
        end
        ACT_ENQ, ACT_ENQ_ALT: begin
          if (fill_r != FILL_FULL) begin
            mem_we   = 1'b1;
            wr_nxt   = wr_inc;
            fill_nxt = (wr_inc == rd_r) ? FILL_FULL : FILL_MID;
            pend_nxt = '{ok: 1'b1, deq: 1'b0, fill: fill_nxt};
          end
        end
      endcase
    end else if (state_r == S_WR2) begin
      mem_we    = 1'b1;
      mem_waddr = sec_addr_r;
      mem_wlo   = sec_lo_r;
      mem_whi   = sec_hi_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = go_wr2 ? S_WR2 : S_OUT;
      S_WR2:  state_nxt = S_OUT;
      S_OUT: begin
        if (in_acc)        state_nxt = go_wr2 ? S_WR2 : S_OUT;
        else if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // store: one write or one read per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      left_mem[mem_waddr]  <= mem_wlo;
      right_mem[mem_waddr] <= mem_whi;
    end
    if (mem_re) begin
      rd_lo_r <= left_mem[rd_r];
      rd_hi_r <= right_mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_r        <= '0;
      wr_r        <= '0;
      fill_r      <= FILL_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (in_acc) begin
      sec_addr_r <= wr_inc;
      sec_lo_r   <= second_lo;
      sec_hi_r   <= second_hi;
    end
    if (out_load) begin
      out_user_r <= pend_r.ok;
      out_data_r <= {{(OUT_TDATA_W - OUT_PAY_W){1'b0}}, pend_r.fill,
                     pend_r.deq ? rd_hi_r : {WORD_W{1'b0}},
                     pend_r.deq ? rd_lo_r : {WORD_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------- checks
  `IPQ_ASSERT_NOW(a_full_ptr, clk, rst_n, fill_r == FILL_FULL, wr_r == rd_r,
    "full status with unequal pointers")
  `IPQ_ASSERT_NOW(a_empty_ptr, clk, rst_n, fill_r == FILL_EMPTY, wr_r == rd_r,
    "empty status with unequal pointers")
  `IPQ_ASSERT_NOW(a_wr2_noacc, clk, rst_n, state_r == S_WR2, !in_tready && mem_we,
    "input taken or write missing during second write")
  `IPQ_ASSERT_NEXT(a_refused_hold, clk, rst_n, in_acc && !pend_nxt.ok,
    $stable(rd_r) && $stable(wr_r) && $stable(fill_r),
    "refused action changed queue state")

endmodule

`default_nettype wire
